// ----- hdl/ecb_pkg.sv -----
// types, constants and table math for the euler-to-camera-basis core
// no dependencies; imported by euler_to_camera_basis_core
package ecb_pkg;

  localparam int OUT_W = 16;
  localparam int IN_W  = 16;

  // pi/2 in q30
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

  typedef struct packed {
    logic [IN_W-1:0] heading_angle;
    logic [IN_W-1:0] pitch_angle;
    logic [IN_W-1:0] bank_angle;
  } ecb_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] forward_x;
    logic signed [OUT_W-1:0] forward_y;
    logic signed [OUT_W-1:0] forward_z;
    logic signed [OUT_W-1:0] up_x;
    logic signed [OUT_W-1:0] up_y;
    logic signed [OUT_W-1:0] up_z;
    logic signed [OUT_W-1:0] right_x;
    logic signed [OUT_W-1:0] right_y;
    logic signed [OUT_W-1:0] right_z;
  } ecb_out_t;

  typedef enum logic {
    ST_FILL,
    ST_RUN
  } ecb_state_t;

  // one quarter-wave sine entry, q30 taylor series rounded half up to frac_bits
  // used at elaboration only
  function automatic logic [31:0] sine_entry(input int unsigned i,
                                             input int unsigned tab_bits,
                                             input int unsigned frac_bits);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] s;
    longint      sum;
    x    = (Q30_HALF_PI * 64'(i)) >> tab_bits;
    x2   = (x * x) >> 30;
    term = x;
    sum  = longint'(x);
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd110; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd156; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd210; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd272; sum = sum + longint'(term);
    term = ((term * x2) >> 30) / 64'd342; sum = sum - longint'(term);
    term = ((term * x2) >> 30) / 64'd420; sum = sum + longint'(term);
    if (sum < 0) sum = 0;
    if (sum > (longint'(1) <<< 30)) sum = longint'(1) <<< 30;
    s = 64'(sum);
    if (frac_bits < 30) s = (s + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    return 32'(s);
  endfunction

endpackage

// ----- hdl/ecb_ram.sv -----
// generic ram: one write port, two read ports with registered read data
// no dependencies
module ecb_ram #(
  parameter int WIDTH = 15,
  parameter int DEPTH = 1025,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr_a,
  input  logic [ADDR_W-1:0] raddr_b,
  output logic [WIDTH-1:0]  rdata_a,
  output logic [WIDTH-1:0]  rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- hdl/euler_to_camera_basis_core.sv -----
// camera basis vectors (forward, up, right) from heading, pitch and bank angles
// depends on ecb_pkg and ecb_ram
//
// The core takes one request of three angles (full turn = 2^ANGLE_BITS) per clock while
// in_ready is high and returns the nine Q1.FRAC_BITS basis components, one result per clock
// when out_ready stays high; bubbles in the pipeline are squeezed out on a stall.
// The six sine/cosine lookups are served by three dual-read sine RAMs (one per angle),
// so each pose uses both read ports of each RAM. After reset the RAMs are loaded
// from the quarter-wave table in a sweep over all 2^TABLE_ADDR_BITS+1 entries (1025 by default)
// during which in_ready stays low; the last table write lands at the edge that can accept
// the first request, the cycle before that request reads the RAMs.
module euler_to_camera_basis_core #(
  parameter int ANGLE_BITS      = 16,
  parameter int FRAC_BITS       = 14,
  parameter int TABLE_ADDR_BITS = 10
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  ecb_pkg::ecb_in_t   in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ecb_pkg::ecb_out_t  out_data
);

  import ecb_pkg::*;

  // widths
  localparam int AW        = ANGLE_BITS;
  localparam int QB        = AW - 2;                 // bits inside a quadrant
  localparam int TAB       = TABLE_ADDR_BITS;
  localparam int ROM_DEPTH = (1 << TAB) + 1;
  localparam int AB        = $clog2(ROM_DEPTH);      // table address
  localparam int FB        = FRAC_BITS;
  localparam int EW        = FB + 1;                 // table entry, 0 .. 1.0
  localparam int TW        = FB + 2;                 // signed trig value
  localparam int PW        = 2 * TW;                 // full product
  localparam int SW        = TW + 1;                 // sum of two rounded products
  localparam int XW        = (SW > OUT_W) ? SW : OUT_W;
  localparam int STAGES    = 8;

  // quadrant-offset to address conversion
  localparam int SFT       = (QB > TAB) ? (QB - TAB) : 1;
  localparam int LSH       = (QB > TAB) ? 0 : (TAB - QB);
  localparam int ROM_LAST_I = 1 << TAB;
  localparam logic [AB-1:0] ROM_LAST = AB'(ROM_LAST_I);
  localparam logic [QB:0]   IDX_HALF = (QB + 1)'(1) << (SFT - 1);
  localparam logic [AW-1:0] QUARTER  = AW'(1) << QB;

  localparam logic signed [PW-1:0] RND     = PW'(1) << (FB - 1);
  localparam logic signed [SW-1:0] ONE     = SW'(1) << FB;
  localparam logic signed [SW-1:0] NEG_ONE = -(SW'(1) << FB);

  // lookup slots; slot pairs share one ram (heading, pitch, bank)
  localparam int IX_SH = 0;
  localparam int IX_CH = 1;
  localparam int IX_SP = 2;
  localparam int IX_CP = 3;
  localparam int IX_SB = 4;
  localparam int IX_CB = 5;
  localparam int NLOOK = 6;

  // quarter-wave sine table, built at elaboration
  typedef logic [EW-1:0] sine_tab_t [ROM_DEPTH];

  function automatic sine_tab_t build_table();
    sine_tab_t t;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      t[i] = EW'(sine_entry(i, TAB, FB));
    end
    t[0]             = '0;
    t[ROM_DEPTH - 1] = EW'(1) << FB;
    return t;
  endfunction

  localparam sine_tab_t SINE_TABLE = build_table();

  // table address for one angle: round the in-quadrant offset, mirror odd quadrants
  function automatic logic [AB-1:0] rom_addr(input logic [AW-1:0] a);
    logic [QB:0]   f_ext;
    logic [AB-1:0] idx;
    if (QB > TAB) begin
      f_ext = {1'b0, a[QB-1:0]} + IDX_HALF;
      idx   = AB'(f_ext >> SFT);
    end else begin
      f_ext = {1'b0, a[QB-1:0]};
      idx   = AB'(f_ext) << LSH;
    end
    if (idx > ROM_LAST) idx = ROM_LAST;
    if (a[QB]) idx = ROM_LAST - idx;
    return idx;
  endfunction

  // round half up to FB fraction bits (floor of product plus half)
  function automatic logic signed [TW-1:0] rnd(input logic signed [PW-1:0] p);
    logic signed [PW-1:0] t;
    t = (p + RND) >>> FB;
    return TW'(t);
  endfunction

  // clamp to +-1.0 and cut to the output width
  function automatic logic [OUT_W-1:0] emit(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    logic signed [XW-1:0] e;
    c = v;
    if (v > ONE) c = ONE;
    if (v < NEG_ONE) c = NEG_ONE;
    e = XW'(c);
    return e[OUT_W-1:0];
  endfunction

  // stage payloads
  typedef struct {
    logic signed [TW-1:0] sp, sh, ch;
    logic signed [PW-1:0] cp_sh, cp_ch, cp_cb, cp_sb, ch_sb, ch_cb, sh_sb, sh_cb;
    logic signed [PW-1:0] sp_cb, sp_sb;
  } s4_t;

  typedef struct {
    logic signed [TW-1:0] sp, sh, ch;
    logic signed [TW-1:0] cp_sh, cp_ch, cp_cb, cp_sb, ch_sb, ch_cb, sh_sb, sh_cb;
    logic signed [TW-1:0] sp_cb, sp_sb;
  } s5_t;

  typedef struct {
    logic signed [TW-1:0] sp;
    logic signed [TW-1:0] cp_sh, cp_ch, cp_cb, cp_sb, ch_sb, ch_cb, sh_sb, sh_cb;
    logic signed [PW-1:0] sh_spcb, ch_spcb, sh_spsb, ch_spsb;
  } s6_t;

  typedef struct {
    logic signed [TW-1:0] sp;
    logic signed [TW-1:0] cp_sh, cp_ch, cp_cb, cp_sb, ch_sb, ch_cb, sh_sb, sh_cb;
    logic signed [TW-1:0] sh_spcb, ch_spcb, sh_spsb, ch_spsb;
  } s7_t;

  // ---------------------------------------------------------------------------
  // table load after reset
  // ---------------------------------------------------------------------------
  ecb_state_t    state_r, state_nxt;
  logic [AB-1:0] fill_idx_r, fill_idx_nxt;
  logic          fill_we_r;
  logic [AB-1:0] fill_addr_r;
  logic [EW-1:0] fill_data_r;
  logic          fill_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_FILL;
      fill_idx_r <= '0;
      fill_we_r  <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      fill_idx_r <= fill_idx_nxt;
      fill_we_r  <= fill_load;
    end
  end

  // table read registered ahead of the ram write
  always_ff @(posedge clk) begin
    if (fill_load) begin
      fill_addr_r <= fill_idx_r;
      fill_data_r <= SINE_TABLE[fill_idx_r];
    end
  end

  always_comb begin
    state_nxt    = state_r;
    fill_idx_nxt = fill_idx_r;
    fill_load    = 1'b0;
    case (state_r)
      ST_FILL: begin
        fill_load = 1'b1;
        if (fill_idx_r == ROM_LAST) begin
          state_nxt = ST_RUN;
        end else begin
          fill_idx_nxt = fill_idx_r + AB'(1);
        end
      end
      ST_RUN: begin
        state_nxt = ST_RUN;
      end
      default: begin
        state_nxt = ST_FILL;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // pipeline flow control: a stage moves when it is empty or its successor moves
  // ---------------------------------------------------------------------------
  logic [STAGES:1] valid_r;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !valid_r[STAGES] || out_ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !valid_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[1] && (state_r == ST_RUN);
  assign out_valid = valid_r[STAGES];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (en[1]) valid_r[1] <= in_valid && (state_r == ST_RUN);
      for (int k = 2; k <= STAGES; k++) begin
        if (en[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: table addresses and sign of each lookup
  // ---------------------------------------------------------------------------
  logic [AW-1:0]    ang [NLOOK];
  logic [AB-1:0]    addr1_r [NLOOK];
  logic [NLOOK-1:0] neg1_r;

  always_comb begin
    ang[IX_SH] = AW'(in_data.heading_angle);
    ang[IX_SP] = AW'(in_data.pitch_angle);
    ang[IX_SB] = AW'(in_data.bank_angle);
    // cosine is sine a quarter turn later
    ang[IX_CH] = ang[IX_SH] + QUARTER;
    ang[IX_CP] = ang[IX_SP] + QUARTER;
    ang[IX_CB] = ang[IX_SB] + QUARTER;
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int i = 0; i < NLOOK; i++) begin
        addr1_r[i] <= rom_addr(ang[i]);
        neg1_r[i]  <= ang[i][AW-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 2: sine rams, one per angle, sine on port a and cosine on port b
  // ---------------------------------------------------------------------------
  logic [EW-1:0]    rd [NLOOK];
  logic [NLOOK-1:0] neg2_r;

  for (genvar g = 0; g < NLOOK / 2; g++) begin : g_ram
    ecb_ram #(
      .WIDTH (EW),
      .DEPTH (ROM_DEPTH)
    ) u_ram (
      .clk     (clk),
      .we      (fill_we_r),
      .waddr   (fill_addr_r),
      .wdata   (fill_data_r),
      .re      (en[2]),
      .raddr_a (addr1_r[2*g]),
      .raddr_b (addr1_r[2*g+1]),
      .rdata_a (rd[2*g]),
      .rdata_b (rd[2*g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en[2]) neg2_r <= neg1_r;
  end

  // ---------------------------------------------------------------------------
  // stage 3: signed sine and cosine values
  // ---------------------------------------------------------------------------
  logic signed [TW-1:0] trig3_r [NLOOK];

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < NLOOK; i++) begin
        trig3_r[i] <= neg2_r[i] ? -$signed({1'b0, rd[i]}) : $signed({1'b0, rd[i]});
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 4: all first-level products in parallel
  // ---------------------------------------------------------------------------
  s4_t s4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_r.sp    <= trig3_r[IX_SP];
      s4_r.sh    <= trig3_r[IX_SH];
      s4_r.ch    <= trig3_r[IX_CH];
      s4_r.cp_sh <= PW'(trig3_r[IX_CP]) * PW'(trig3_r[IX_SH]);
      s4_r.cp_ch <= PW'(trig3_r[IX_CP]) * PW'(trig3_r[IX_CH]);
      s4_r.cp_cb <= PW'(trig3_r[IX_CP]) * PW'(trig3_r[IX_CB]);
      s4_r.cp_sb <= PW'(trig3_r[IX_CP]) * PW'(trig3_r[IX_SB]);
      s4_r.ch_sb <= PW'(trig3_r[IX_CH]) * PW'(trig3_r[IX_SB]);
      s4_r.ch_cb <= PW'(trig3_r[IX_CH]) * PW'(trig3_r[IX_CB]);
      s4_r.sh_sb <= PW'(trig3_r[IX_SH]) * PW'(trig3_r[IX_SB]);
      s4_r.sh_cb <= PW'(trig3_r[IX_SH]) * PW'(trig3_r[IX_CB]);
      s4_r.sp_cb <= PW'(trig3_r[IX_SP]) * PW'(trig3_r[IX_CB]);
      s4_r.sp_sb <= PW'(trig3_r[IX_SP]) * PW'(trig3_r[IX_SB]);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 5: round first-level products
  // ---------------------------------------------------------------------------
  s5_t s5_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_r.sp    <= s4_r.sp;
      s5_r.sh    <= s4_r.sh;
      s5_r.ch    <= s4_r.ch;
      s5_r.cp_sh <= rnd(s4_r.cp_sh);
      s5_r.cp_ch <= rnd(s4_r.cp_ch);
      s5_r.cp_cb <= rnd(s4_r.cp_cb);
      s5_r.cp_sb <= rnd(s4_r.cp_sb);
      s5_r.ch_sb <= rnd(s4_r.ch_sb);
      s5_r.ch_cb <= rnd(s4_r.ch_cb);
      s5_r.sh_sb <= rnd(s4_r.sh_sb);
      s5_r.sh_cb <= rnd(s4_r.sh_cb);
      s5_r.sp_cb <= rnd(s4_r.sp_cb);
      s5_r.sp_sb <= rnd(s4_r.sp_sb);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 6: triple products, inner pair already rounded
  // ---------------------------------------------------------------------------
  s6_t s6_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s6_r.sp      <= s5_r.sp;
      s6_r.cp_sh   <= s5_r.cp_sh;
      s6_r.cp_ch   <= s5_r.cp_ch;
      s6_r.cp_cb   <= s5_r.cp_cb;
      s6_r.cp_sb   <= s5_r.cp_sb;
      s6_r.ch_sb   <= s5_r.ch_sb;
      s6_r.ch_cb   <= s5_r.ch_cb;
      s6_r.sh_sb   <= s5_r.sh_sb;
      s6_r.sh_cb   <= s5_r.sh_cb;
      s6_r.sh_spcb <= PW'(s5_r.sh) * PW'(s5_r.sp_cb);
      s6_r.ch_spcb <= PW'(s5_r.ch) * PW'(s5_r.sp_cb);
      s6_r.sh_spsb <= PW'(s5_r.sh) * PW'(s5_r.sp_sb);
      s6_r.ch_spsb <= PW'(s5_r.ch) * PW'(s5_r.sp_sb);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 7: round triple products
  // ---------------------------------------------------------------------------
  s7_t s7_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_r.sp      <= s6_r.sp;
      s7_r.cp_sh   <= s6_r.cp_sh;
      s7_r.cp_ch   <= s6_r.cp_ch;
      s7_r.cp_cb   <= s6_r.cp_cb;
      s7_r.cp_sb   <= s6_r.cp_sb;
      s7_r.ch_sb   <= s6_r.ch_sb;
      s7_r.ch_cb   <= s6_r.ch_cb;
      s7_r.sh_sb   <= s6_r.sh_sb;
      s7_r.sh_cb   <= s6_r.sh_cb;
      s7_r.sh_spcb <= rnd(s6_r.sh_spcb);
      s7_r.ch_spcb <= rnd(s6_r.ch_spcb);
      s7_r.sh_spsb <= rnd(s6_r.sh_spsb);
      s7_r.ch_spsb <= rnd(s6_r.ch_spsb);
    end
  end

  // ---------------------------------------------------------------------------
  // stage 8: sums, saturation, output register
  // ---------------------------------------------------------------------------
  ecb_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (en[8]) begin
      out_data_r.forward_x <= emit(-SW'(s7_r.cp_sh));
      out_data_r.forward_y <= emit(SW'(s7_r.sp));
      out_data_r.forward_z <= emit(-SW'(s7_r.cp_ch));
      out_data_r.up_x      <= emit(SW'(s7_r.sh_spcb) - SW'(s7_r.ch_sb));
      out_data_r.up_y      <= emit(SW'(s7_r.cp_cb));
      out_data_r.up_z      <= emit(SW'(s7_r.sh_sb) + SW'(s7_r.ch_spcb));
      out_data_r.right_x   <= emit(SW'(s7_r.ch_cb) + SW'(s7_r.sh_spsb));
      out_data_r.right_y   <= emit(SW'(s7_r.cp_sb));
      out_data_r.right_z   <= emit(SW'(s7_r.ch_spsb) - SW'(s7_r.sh_cb));
    end
  end

  assign out_data = out_data_r;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------

  // nothing is in flight while the table is still loading
  a_empty_during_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (valid_r == '0))
    else $error("pipeline holds a request during table load");

  // the table is never written once lookups may be running
  a_no_late_fill: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_RUN) && $past(state_r == ST_RUN)) |-> !fill_we_r)
    else $error("sine ram written after load finished");

  // an accepted request always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> valid_r[1])
    else $error("accepted request lost at stage one");

endmodule
